>>> hw/rtl/shader_module_instruction_filter_assert.svh
// ============================================================================
// Assertion macros for the shader module instruction filter
// Implication checks on the block clock, masked while reset is low.
// ============================================================================
`ifndef SHADER_MODULE_INSTRUCTION_FILTER_ASSERT_SVH
`define SHADER_MODULE_INSTRUCTION_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SMIF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("smif: same-cycle check failed");
`define SMIF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("smif: next-cycle check failed");
`else
`define SMIF_ASSERT_IMP(label, ante, cons)
`define SMIF_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> hw/rtl/smif_pkg.sv
// ============================================================================
// smif_pkg
// Shared types and codes of the shader module instruction filter.
// ============================================================================
package smif_pkg;

    localparam int HOLD_WORDS_DEF = 9;
    localparam int MAX_WORDS_DEF  = 1048576;

    localparam int KEPT_TOTAL_W = 21;

    // result kinds
    localparam logic [1:0] KIND_KEPT  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // error codes
    localparam logic [1:0] ERR_BAD_MAGIC    = 2'd0;
    localparam logic [1:0] ERR_SHORT_HEADER = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED    = 2'd2;
    localparam logic [1:0] ERR_ZERO_LENGTH  = 2'd3;

    typedef struct packed {
        logic [31:0] word;
        logic        end_of_module;
    } smif_in_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic [31:0]             kept_word;
        logic [KEPT_TOTAL_W-1:0] kept_total;
        logic [1:0]              error_code;
        logic                    last_of_run;
    } smif_out_t;

    typedef struct packed {
        logic accept;   // input request taken this cycle
        logic issue;    // load next result into the output register
    } smif_cmd_t;

    typedef struct packed {
        logic plan_busy;   // request being taken produces results
        logic out_free;    // output register can take a result
        logic issue_last;  // result up next is the final one of its run
    } smif_sts_t;

endpackage

>>> hw/rtl/shader_module_instruction_filter.sv
// ============================================================================
// shader_module_instruction_filter
// Strips debug, string and selected decoration/extension instructions from
// a binary shader module streamed one word per request.
// ============================================================================
//
//  Channel  Dir  Handshake          Payload (smif_pkg)
//  s_       in   s_valid/s_ready    smif_in_t : word, end_of_module
//  m_       out  m_valid/m_ready    smif_out_t: kind, kept_word, kept_total,
//                                               error_code, last_of_run
//
//  A request is taken while the sequencer is idle; each result it causes is
//  then loaded into the single output register, so a word gives n results
//  with n from 0 to HOLD_WORDS + 1 (one for a plain kept word, none for a
//  dropped one). The emit counter fills the output register one result per
//  cycle from the hold buffer while m_ready does not stall it.
//  s_ready is low while results of the last request are still being loaded;
//  m_ready low stalls that loading. The last result may wait in the output
//  register while the next request is taken.
//  aresetn (synchronous, active low) returns the parser to the start of a
//  module; hold buffer contents are not cleared.
//
`include "shader_module_instruction_filter_assert.svh"

module shader_module_instruction_filter #(
    parameter int HOLD_WORDS = smif_pkg::HOLD_WORDS_DEF,
    parameter int MAX_WORDS  = smif_pkg::MAX_WORDS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  smif_pkg::smif_in_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output smif_pkg::smif_out_t m_item
);
    import smif_pkg::*;

    smif_cmd_t cmd;
    smif_sts_t sts;

    // sequencer: IDLE takes a request, EMIT streams its results
    smif_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // parser state, hold buffer, name compare, kept count, output register
    smif_dp #(
        .HOLD_WORDS (HOLD_WORDS),
        .MAX_WORDS  (MAX_WORDS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // results are never loaded while a new request is being taken
    `SMIF_ASSERT_IMP(a_no_take_while_emitting, cmd.issue, !s_ready)
    // a request with no results leaves the block ready for the next one
    `SMIF_ASSERT_NXT(a_ready_after_silent, cmd.accept && !sts.plan_busy, s_ready)
    // end and error reports always close their run
    `SMIF_ASSERT_IMP(a_report_is_last, m_valid && m_item.kind != KIND_KEPT, m_item.last_of_run)

endmodule

>>> hw/rtl/smif_ctrl.sv
// ============================================================================
// smif_ctrl
// Two-state sequencer: take a request, then stream its results out.
// ============================================================================
module smif_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  smif_pkg::smif_sts_t sts,
    output smif_pkg::smif_cmd_t cmd
);
    import smif_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg;
    logic state_next;

    assign s_ready    = (state_reg == ST_IDLE);
    assign cmd.accept = s_valid && s_ready;
    assign cmd.issue  = (state_reg == ST_EMIT) && sts.out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.accept && sts.plan_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (cmd.issue && sts.issue_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/smif_dp.sv
// ============================================================================
// smif_dp
// Parser state, hold buffer, name compare, kept counter and output register.
// ============================================================================
module smif_dp #(
    parameter int HOLD_WORDS = smif_pkg::HOLD_WORDS_DEF,
    parameter int MAX_WORDS  = smif_pkg::MAX_WORDS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  smif_pkg::smif_in_t  s_item,
    input  smif_pkg::smif_cmd_t cmd,
    output smif_pkg::smif_sts_t sts,
    output logic                m_valid,
    input  logic                m_ready,
    output smif_pkg::smif_out_t m_item
);
    import smif_pkg::*;

    localparam int HCW = $clog2(HOLD_WORDS + 1);
    localparam int HIW = $clog2(HOLD_WORDS);
    localparam int KCW = $clog2(MAX_WORDS + 1);

    localparam logic [31:0] MAGIC_WORD   = 32'h0723_0203;
    localparam logic [2:0]  HEADER_WORDS = 3'd5;

    localparam logic [15:0] OP_SOURCE_CONTINUED       = 16'd2;
    localparam logic [15:0] OP_SOURCE                 = 16'd3;
    localparam logic [15:0] OP_STRING                 = 16'd7;
    localparam logic [15:0] OP_LINE                   = 16'd8;
    localparam logic [15:0] OP_EXTENSION              = 16'd10;
    localparam logic [15:0] OP_MODULE_PROCESSED       = 16'd330;
    localparam logic [15:0] OP_DECORATE_ID            = 16'd332;
    localparam logic [15:0] OP_DECORATE_STRING        = 16'd5632;
    localparam logic [15:0] OP_MEMBER_DECORATE_STRING = 16'd5633;

    localparam logic [31:0] DECO_COUNTER_BUFFER = 32'd5634;
    localparam logic [31:0] DECO_USER_TYPE      = 32'd5636;

    localparam logic [1:0] DEC_UNDECIDED = 2'd0;
    localparam logic [1:0] DEC_KEEP      = 2'd1;
    localparam logic [1:0] DEC_DROP      = 2'd2;

    localparam logic [1:0] IK_PLAIN = 2'd0;
    localparam logic [1:0] IK_DECID = 2'd1;
    localparam logic [1:0] IK_EXT   = 2'd2;

    localparam logic [1:0] REP_NONE  = 2'd0;
    localparam logic [1:0] REP_END   = 2'd1;
    localparam logic [1:0] REP_ERROR = 2'd2;

    localparam logic [1:0] EXT_A = 2'd0;
    localparam logic [1:0] EXT_B = 2'd1;
    localparam logic [1:0] EXT_C = 2'd2;

    // extension names, little-endian, name word i = instruction word i+1
    function automatic logic [31:0] ext_word(input logic [1:0] k, input logic [2:0] i);
        logic [31:0] r;
        r = '0;
        unique case (i)
            3'd0: r = 32'h5F56_5053;
            3'd1: r = 32'h474F_4F47;
            3'd2: begin
                unique case (k)
                    EXT_A:   r = 32'h645F_454C;
                    EXT_B:   r = 32'h685F_454C;
                    default: r = 32'h755F_454C;
                endcase
            end
            3'd3: begin
                unique case (k)
                    EXT_A:   r = 32'h726F_6365;
                    EXT_B:   r = 32'h5F6C_736C;
                    default: r = 32'h5F72_6573;
                endcase
            end
            3'd4: begin
                unique case (k)
                    EXT_A:   r = 32'h5F65_7461;
                    EXT_B:   r = 32'h636E_7566;
                    default: r = 32'h6570_7974;
                endcase
            end
            3'd5: begin
                unique case (k)
                    EXT_A:   r = 32'h6972_7473;
                    EXT_B:   r = 32'h6E6F_6974;
                    default: r = 32'h0000_0000;
                endcase
            end
            3'd6: begin
                unique case (k)
                    EXT_A:   r = 32'h0000_676E;
                    EXT_B:   r = 32'h7469_6C61;
                    default: r = 32'h0000_0000;
                endcase
            end
            default: begin
                unique case (k)
                    EXT_B:   r = 32'h0000_3179;
                    default: r = 32'h0000_0000;
                endcase
            end
        endcase
        return r;
    endfunction

    // instruction word index holding the terminating NUL
    function automatic logic [3:0] ext_last(input logic [1:0] k);
        logic [3:0] r;
        unique case (k)
            EXT_A:   r = 4'd7;
            EXT_B:   r = 4'd8;
            default: r = 4'd6;
        endcase
        return r;
    endfunction

    // bytes past the NUL are not compared
    function automatic logic [31:0] ext_mask(input logic [1:0] k, input logic [2:0] i);
        logic [31:0] r;
        logic [3:0]  wi;
        wi = {1'b0, i} + 4'd1;
        r  = '0;
        if (wi < ext_last(k)) begin
            r = '1;
        end else if (wi == ext_last(k)) begin
            unique case (k)
                EXT_C:   r = 32'h0000_00FF;
                default: r = 32'h00FF_FFFF;
            endcase
        end
        return r;
    endfunction

    // parser state
    logic [2:0]     header_seen_reg;
    logic [15:0]    words_left_reg;
    logic [3:0]     word_index_reg;
    logic [1:0]     instr_kind_reg;
    logic [1:0]     decision_reg;
    logic [2:0]     name_match_reg;
    logic [HCW-1:0] hold_count_reg;
    logic           error_seen_reg;
    logic [KCW-1:0] kept_count_reg;
    logic [31:0]    hold_mem [HOLD_WORDS];

    // emission plan
    logic [HCW-1:0] emit_total_reg;
    logic [HCW-1:0] emit_idx_reg;
    logic [1:0]     rep_kind_reg;
    logic [1:0]     rep_code_reg;

    logic      m_valid_reg;
    smif_out_t m_item_reg;

    // request decode
    logic [31:0] in_word;
    logic        in_eom;
    logic [15:0] in_len;
    logic [15:0] in_op;

    logic [2:0]     hs_next;
    logic [15:0]    wl_next;
    logic [3:0]     wi_next;
    logic [1:0]     ik_next;
    logic [1:0]     dec_next;
    logic [2:0]     nm_next;
    logic [HCW-1:0] hc_next;
    logic           es_next;
    logic [HCW-1:0] hc_inc;
    logic [HCW-1:0] emit_next;
    logic [1:0]     rep_next;
    logic           take;
    logic           wr_en;
    logic [HIW-1:0] wr_idx;
    logic           err_en;
    logic [1:0]     err_code;
    logic [2:0]     tbl_idx;
    logic [2:0]     hits;

    logic issue_word;

    assign in_word = s_item.word;
    assign in_eom  = s_item.end_of_module;
    assign in_len  = in_word[31:16];
    assign in_op   = in_word[15:0];

    always_comb begin
        hs_next  = header_seen_reg;
        wl_next  = words_left_reg;
        wi_next  = word_index_reg;
        ik_next  = instr_kind_reg;
        dec_next = decision_reg;
        nm_next  = name_match_reg;
        hc_next  = hold_count_reg;
        es_next  = error_seen_reg;
        hc_inc   = hold_count_reg;
        emit_next = '0;
        take     = 1'b0;
        wr_en    = 1'b0;
        wr_idx   = '0;
        err_en   = 1'b0;
        err_code = ERR_BAD_MAGIC;
        tbl_idx  = '0;
        hits     = '0;

        if (error_seen_reg) begin
            // skipping to end of module
        end else if (header_seen_reg < HEADER_WORDS) begin
            if (header_seen_reg == '0 && in_word != MAGIC_WORD) begin
                err_en   = 1'b1;
                err_code = ERR_BAD_MAGIC;
            end else begin
                wr_en     = 1'b1;
                emit_next = HCW'(1);
                hs_next   = header_seen_reg + 3'd1;
                if (in_eom && hs_next < HEADER_WORDS) begin
                    err_en   = 1'b1;
                    err_code = ERR_SHORT_HEADER;
                end
            end
        end else if (words_left_reg == '0) begin
            if (in_len == '0) begin
                err_en   = 1'b1;
                err_code = ERR_ZERO_LENGTH;
            end else begin
                wl_next  = in_len - 16'd1;
                wi_next  = '0;
                hc_next  = '0;
                nm_next  = 3'b111;
                ik_next  = IK_PLAIN;
                dec_next = DEC_UNDECIDED;
                unique case (in_op) inside
                    OP_SOURCE_CONTINUED, OP_SOURCE, OP_STRING, OP_LINE,
                    OP_MODULE_PROCESSED, OP_DECORATE_STRING,
                    OP_MEMBER_DECORATE_STRING: dec_next = DEC_DROP;
                    OP_DECORATE_ID:            ik_next  = IK_DECID;
                    OP_EXTENSION:              ik_next  = IK_EXT;
                    default:                   dec_next = DEC_KEEP;
                endcase
                take = 1'b1;
            end
        end else begin
            wl_next = words_left_reg - 16'd1;
            if (word_index_reg != '1) begin
                wi_next = word_index_reg + 4'd1;
            end
            take = 1'b1;
        end

        if (take) begin
            if (dec_next == DEC_KEEP) begin
                wr_en     = 1'b1;
                wr_idx    = hc_next[HIW-1:0];
                emit_next = HCW'(1);
            end else if (dec_next == DEC_UNDECIDED) begin
                wr_en  = 1'b1;
                wr_idx = hc_next[HIW-1:0];
                hc_inc = hc_next + HCW'(1);
                if (ik_next == IK_DECID && wi_next == 4'd2) begin
                    dec_next = (in_word == DECO_COUNTER_BUFFER || in_word == DECO_USER_TYPE)
                             ? DEC_DROP : DEC_KEEP;
                end else if (ik_next == IK_EXT && wi_next >= 4'd1 && wi_next <= 4'd8) begin
                    tbl_idx = 3'(wi_next - 4'd1);
                    for (int k = 0; k < 3; k++) begin
                        hits[k] = ((in_word ^ ext_word(2'(k), tbl_idx))
                                  & ext_mask(2'(k), tbl_idx)) == '0;
                    end
                    nm_next = nm_next & hits;
                    for (int k = 0; k < 3; k++) begin
                        if (nm_next[k] && wi_next == ext_last(2'(k))) begin
                            dec_next = DEC_DROP;
                        end
                    end
                    if (dec_next == DEC_UNDECIDED && nm_next == '0) begin
                        dec_next = DEC_KEEP;
                    end
                end
                if (dec_next == DEC_UNDECIDED
                    && (wl_next == '0 || hc_inc >= HCW'(HOLD_WORDS))) begin
                    dec_next = DEC_KEEP;
                end
                if (dec_next == DEC_KEEP) begin
                    emit_next = hc_inc;
                end
                hc_next = (dec_next != DEC_UNDECIDED) ? '0 : hc_inc;
            end
        end

        if (!error_seen_reg && !err_en && in_eom && wl_next != '0) begin
            err_en   = 1'b1;
            err_code = ERR_TRUNCATED;
        end
        if (err_en) begin
            es_next = 1'b1;
        end

        rep_next = REP_NONE;
        if (!error_seen_reg) begin
            if (err_en) begin
                rep_next = REP_ERROR;
            end else if (in_eom) begin
                rep_next = REP_END;
            end
        end
    end

    assign issue_word     = emit_idx_reg < emit_total_reg;
    assign sts.plan_busy  = (emit_next != '0) || (rep_next != REP_NONE);
    assign sts.out_free   = !m_valid_reg || m_ready;
    assign sts.issue_last = issue_word
                          ? ((emit_idx_reg + HCW'(1) == emit_total_reg) && rep_kind_reg == REP_NONE)
                          : 1'b1;

    always_ff @(posedge aclk) begin
        if (cmd.accept && wr_en) begin
            hold_mem[wr_idx] <= in_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_seen_reg <= '0;
            words_left_reg  <= '0;
            word_index_reg  <= '0;
            instr_kind_reg  <= IK_PLAIN;
            decision_reg    <= DEC_UNDECIDED;
            name_match_reg  <= 3'b111;
            hold_count_reg  <= '0;
            error_seen_reg  <= 1'b0;
            kept_count_reg  <= '0;
            emit_total_reg  <= '0;
            emit_idx_reg    <= '0;
            rep_kind_reg    <= REP_NONE;
            rep_code_reg    <= ERR_BAD_MAGIC;
        end else if (cmd.accept) begin
            if (in_eom) begin
                header_seen_reg <= '0;
                words_left_reg  <= '0;
                word_index_reg  <= '0;
                instr_kind_reg  <= IK_PLAIN;
                decision_reg    <= DEC_UNDECIDED;
                name_match_reg  <= 3'b111;
                hold_count_reg  <= '0;
                error_seen_reg  <= 1'b0;
            end else begin
                header_seen_reg <= hs_next;
                words_left_reg  <= wl_next;
                word_index_reg  <= wi_next;
                instr_kind_reg  <= ik_next;
                decision_reg    <= dec_next;
                name_match_reg  <= nm_next;
                hold_count_reg  <= hc_next;
                error_seen_reg  <= es_next;
            end
            // silent end of a failed module: nothing will report the count
            if (error_seen_reg && in_eom) begin
                kept_count_reg <= '0;
            end
            emit_total_reg <= emit_next;
            emit_idx_reg   <= '0;
            rep_kind_reg   <= rep_next;
            rep_code_reg   <= err_code;
        end else if (cmd.issue) begin
            if (issue_word) begin
                emit_idx_reg <= emit_idx_reg + HCW'(1);
                if (kept_count_reg < KCW'(MAX_WORDS)) begin
                    kept_count_reg <= kept_count_reg + KCW'(1);
                end
            end else begin
                kept_count_reg <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.issue) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.issue) begin
            m_item_reg.last_of_run <= sts.issue_last;
            if (issue_word) begin
                m_item_reg.kind       <= KIND_KEPT;
                m_item_reg.kept_word  <= hold_mem[emit_idx_reg[HIW-1:0]];
                m_item_reg.kept_total <= '0;
                m_item_reg.error_code <= '0;
            end else if (rep_kind_reg == REP_ERROR) begin
                m_item_reg.kind       <= KIND_ERROR;
                m_item_reg.kept_word  <= '0;
                m_item_reg.kept_total <= '0;
                m_item_reg.error_code <= rep_code_reg;
            end else begin
                m_item_reg.kind       <= KIND_END;
                m_item_reg.kept_word  <= '0;
                m_item_reg.kept_total <= KEPT_TOTAL_W'(kept_count_reg);
                m_item_reg.error_code <= '0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

>>> sim/tb_shader_module_instruction_filter.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_shader_module_instruction_filter
// Streams shader modules into the instruction filter and checks every result
// against an in-bench predictor of the stripping rules. Directed modules hit
// the four error paths, then random modules (mostly well formed, some broken)
// run under three handshake idle profiles.
// ============================================================================
module tb_shader_module_instruction_filter;
    import smif_pkg::*;

    // ------------------------------------------------------------------------
    // Opcodes, decorations and name tables of the stripping rules
    // ------------------------------------------------------------------------
    localparam logic [31:0] MAGIC_WORD = 32'h0723_0203;

    localparam logic [15:0] OP_UNDEF                  = 16'd1;
    localparam logic [15:0] OP_SOURCE_CONT            = 16'd2;
    localparam logic [15:0] OP_SOURCE                 = 16'd3;
    localparam logic [15:0] OP_STRING                 = 16'd7;
    localparam logic [15:0] OP_LINE                   = 16'd8;
    localparam logic [15:0] OP_EXTENSION              = 16'd10;
    localparam logic [15:0] OP_MODULE_PROCESSED       = 16'd330;
    localparam logic [15:0] OP_DECORATE_ID            = 16'd332;
    localparam logic [15:0] OP_DECORATE_STRING        = 16'd5632;
    localparam logic [15:0] OP_MEMBER_DECORATE_STRING = 16'd5633;

    localparam logic [31:0] DEC_COUNTER_BUFFER = 32'd5634;
    localparam logic [31:0] DEC_SEMANTIC       = 32'd5635;   // neighbor, must be kept
    localparam logic [31:0] DEC_USER_TYPE      = 32'd5636;

    localparam int HOLD_DEPTH = HOLD_WORDS_DEF;

    // Extension names packed as little-endian words, starting at word 1 of
    // the instruction. The word after the last full one carries the NUL.
    localparam logic [31:0] EXT_NAME_WORD [3][8] = '{
        '{32'h5F565053, 32'h474F4F47, 32'h645F454C, 32'h726F6365,
          32'h5F657461, 32'h69727473, 32'h0000676E, 32'h00000000},
        '{32'h5F565053, 32'h474F4F47, 32'h685F454C, 32'h5F6C736C,
          32'h636E7566, 32'h6E6F6974, 32'h74696C61, 32'h00003179},
        '{32'h5F565053, 32'h474F4F47, 32'h755F454C, 32'h5F726573,
          32'h65707974, 32'h00000000, 32'h00000000, 32'h00000000}
    };
    localparam int EXT_NAME_LEN [3] = '{26, 30, 20};

    localparam int RANDOM_ITEMS = 190;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum logic [1:0] {V_UNDECIDED, V_KEEP, V_DROP} verdict_t;
    typedef enum logic [1:0] {IK_PLAIN, IK_DECOR, IK_EXT} instr_kind_t;

    typedef logic [31:0] word_q_t [$];

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the results of each accepted request and checks
    // the results the block hands out, oldest first.
    // ------------------------------------------------------------------------
    class strip_scoreboard_t;
        logic [2:0]   hdr_cnt;
        logic [15:0]  remain;
        logic [15:0]  pos;
        instr_kind_t  ikind;
        verdict_t     verdict;
        logic [2:0]   cand;
        logic [31:0]  held [HOLD_DEPTH];
        int unsigned  held_cnt;
        logic [20:0]  kept_cnt;
        bit           in_error;
        smif_out_t    due_results [$];
        int           mismatches;

        function new();
            restart();
            mismatches = 0;
        endfunction

        function void restart();
            hdr_cnt  = '0;
            remain   = '0;
            pos      = '0;
            ikind    = IK_PLAIN;
            verdict  = V_UNDECIDED;
            cand     = 3'b111;
            held_cnt = 0;
            kept_cnt = '0;
            in_error = 0;
        endfunction

        function void push_result(logic [1:0] kind, logic [31:0] w, logic [20:0] tot,
                                  logic [1:0] code);
            smif_out_t r;
            r = '0;
            r.kind       = kind;
            r.kept_word  = w;
            r.kept_total = tot;
            r.error_code = code;
            due_results.insert(due_results.size(), r);
        endfunction

        function void pass_word(logic [31:0] w);
            push_result(KIND_KEPT, w, '0, '0);
            if (kept_cnt < MAX_WORDS_DEF) kept_cnt++;
        endfunction

        // Narrow the set of extension names still matching; bytes past the
        // name's terminator are not compared.
        function void match_name(logic [31:0] w);
            int p;
            logic [7:0] want;
            if (pos < 1 || pos > 8) return;
            for (int k = 0; k < 3; k++) begin
                if (!cand[k]) continue;
                for (int b = 0; b < 4; b++) begin
                    p = 4 * (pos - 1) + b;
                    if (p > EXT_NAME_LEN[k]) break;
                    want = EXT_NAME_WORD[k][pos - 1][8 * b +: 8];
                    if (w[8 * b +: 8] != want) begin
                        cand[k] = 1'b0;
                        break;
                    end
                end
                if (cand[k] && pos == EXT_NAME_LEN[k] / 4 + 1) verdict = V_DROP;
            end
            if (verdict == V_UNDECIDED && cand == 3'b000) verdict = V_KEEP;
        endfunction

        function void take(logic [31:0] w);
            if (verdict == V_KEEP) begin
                pass_word(w);
                return;
            end
            if (verdict == V_DROP) return;
            if (held_cnt < HOLD_DEPTH) begin
                held[held_cnt] = w;
                held_cnt++;
            end
            if (ikind == IK_DECOR && pos == 2)
                verdict = (w == DEC_COUNTER_BUFFER || w == DEC_USER_TYPE) ? V_DROP : V_KEEP;
            else if (ikind == IK_EXT)
                match_name(w);
            if (verdict == V_UNDECIDED && (remain == 0 || held_cnt >= HOLD_DEPTH))
                verdict = V_KEEP;
            if (verdict == V_KEEP)
                for (int i = 0; i < held_cnt; i++) pass_word(held[i]);
            if (verdict != V_UNDECIDED) held_cnt = 0;
        endfunction

        function void note_request(smif_in_t req);
            logic [31:0] w;
            logic        eom;
            int          first;
            bit          has_err;
            logic [1:0]  code;
            logic [15:0] op;
            w       = req.word;
            eom     = req.end_of_module;
            first   = due_results.size();
            has_err = 0;
            code    = '0;
            // after an error the rest of the module is swallowed
            if (in_error) begin
                if (eom) restart();
                return;
            end
            if (hdr_cnt < 5) begin
                if (hdr_cnt == 0 && w != MAGIC_WORD) begin
                    has_err = 1;
                    code    = ERR_BAD_MAGIC;
                end else begin
                    pass_word(w);
                    hdr_cnt++;
                    if (eom && hdr_cnt < 5) begin
                        has_err = 1;
                        code    = ERR_SHORT_HEADER;
                    end
                end
            end else if (remain == 0) begin
                op = w[15:0];
                if (w[31:16] == 16'd0) begin
                    has_err = 1;
                    code    = ERR_ZERO_LENGTH;
                end else begin
                    remain   = w[31:16] - 16'd1;
                    pos      = '0;
                    held_cnt = 0;
                    cand     = 3'b111;
                    ikind    = IK_PLAIN;
                    verdict  = V_UNDECIDED;
                    if (op inside {OP_SOURCE_CONT, OP_SOURCE, OP_STRING, OP_LINE,
                                   OP_MODULE_PROCESSED, OP_DECORATE_STRING,
                                   OP_MEMBER_DECORATE_STRING})
                        verdict = V_DROP;
                    else if (op == OP_DECORATE_ID)
                        ikind = IK_DECOR;
                    else if (op == OP_EXTENSION)
                        ikind = IK_EXT;
                    else
                        verdict = V_KEEP;
                    take(w);
                end
            end else begin
                remain--;
                if (pos != 16'hFFFF) pos++;
                take(w);
            end
            if (!has_err && eom && remain != 0) begin
                has_err = 1;
                code    = ERR_TRUNCATED;
            end
            if (has_err) begin
                push_result(KIND_ERROR, '0, '0, code);
                if (eom) restart();
                else in_error = 1;
            end else if (eom) begin
                push_result(KIND_END, '0, kept_cnt, '0);
                restart();
            end
            if (due_results.size() > first)
                due_results[due_results.size() - 1].last_of_run = 1'b1;
        endfunction

        function void check_result(smif_out_t got);
            smif_out_t want;
            if (due_results.size() == 0) begin
                mismatches++;
                $display("%0t: expected no result / actual kind=%0d word=%h total=%0d",
                         $time, got.kind, got.kept_word, got.kept_total,
                         " code=%0d last=%0b", got.error_code, got.last_of_run);
                return;
            end
            want = due_results.pop_front();
            if (got.kind !== want.kind || got.kept_word !== want.kept_word ||
                got.kept_total !== want.kept_total || got.error_code !== want.error_code ||
                got.last_of_run !== want.last_of_run) begin
                mismatches++;
                $display("%0t: expected kind=%0d word=%h total=%0d code=%0d last=%0b",
                         $time, want.kind, want.kept_word, want.kept_total,
                         want.error_code, want.last_of_run,
                         " / actual kind=%0d word=%h total=%0d code=%0d last=%0b",
                         got.kind, got.kept_word, got.kept_total, got.error_code,
                         got.last_of_run);
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, block
    // ------------------------------------------------------------------------
    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    smif_in_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    smif_out_t m_item;

    strip_scoreboard_t sb = new();

    int send_idle_pct = 15;
    int recv_idle_pct = 46;
    int n_sent        = 0;
    int cycle_cnt     = 0;

    always #2 aclk = ~aclk;

    shader_module_instruction_filter dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Receiver: ready changes on the falling edge, stalls per the profile.
    always @(negedge aclk)
        m_ready <= aresetn && ($urandom_range(0, 99) >= recv_idle_pct);

    // Results are taken at the rising edge where valid and ready meet.
    always @(posedge aclk)
        if (aresetn && m_valid && m_ready) sb.check_result(m_item);

    // Hang guard: ends the run as a failure if the stream never drains.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender tasks. Each one is entered and left on a falling edge.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [31:0] w, input logic eom);
        smif_in_t req;
        // idle cycles drawn one at a time per the profile
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        req.word          = w;
        req.end_of_module = eom;
        s_item  <= req;
        s_valid <= 1'b1;
        // hold the request until the block takes it
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic send_module(input word_q_t q);
        foreach (q[i]) send_request(q[i], i == q.size() - 1);
    endtask

    // Pause the sender until every predicted result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Random module builders
    // ------------------------------------------------------------------------

    // Extension instruction: one of the three listed names, a look-alike that
    // shares the prefix, a corrupted name, or a length that cuts the name.
    function automatic void add_ext_instr(ref word_q_t q);
        int          k;
        int          nw;
        int          len;
        int          bad_at;
        logic [31:0] w;
        logic [63:0] keep_mask;
        k      = $urandom_range(0, 3);
        nw     = (k < 3) ? EXT_NAME_LEN[k] / 4 + 1 : $urandom_range(1, 8);
        bad_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, nw) : 0;
        case ($urandom_range(0, 5))
            0:       len = $urandom_range(1, nw);
            1:       len = nw + 1 + $urandom_range(1, 3);
            default: len = nw + 1;
        endcase
        q.insert(q.size(), {16'(len), OP_EXTENSION});
        for (int i = 1; i < len; i++) begin
            w = $urandom;
            if (k < 3 && i <= nw) begin
                w = EXT_NAME_WORD[k][i - 1];
                if (i == nw) begin
                    // bytes past the terminator are don't-care
                    keep_mask = (64'd1 << (8 * (EXT_NAME_LEN[k] % 4 + 1))) - 64'd1;
                    w = (w & keep_mask[31:0]) | ($urandom & ~keep_mask[31:0]);
                end
            end else if (k == 3 && i <= 2) begin
                w = EXT_NAME_WORD[0][i - 1];
            end
            if (i == bad_at) w ^= 32'd1 << $urandom_range(0, 31);
            q.insert(q.size(), w);
        end
    endfunction

    function automatic void add_instr(ref word_q_t q);
        int          len;
        logic [15:0] op;
        logic [31:0] w;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                op  = 16'($urandom);
                len = $urandom_range(1, 5);
            end
            3: begin
                case ($urandom_range(0, 6))
                    0: op = OP_SOURCE_CONT;
                    1: op = OP_SOURCE;
                    2: op = OP_STRING;
                    3: op = OP_LINE;
                    4: op = OP_MODULE_PROCESSED;
                    5: op = OP_DECORATE_STRING;
                    default: op = OP_MEMBER_DECORATE_STRING;
                endcase
                len = $urandom_range(1, 4);
            end
            4: begin
                op  = OP_DECORATE_ID;
                len = $urandom_range(1, 5);
            end
            5, 6, 7: begin
                add_ext_instr(q);
                return;
            end
            default: begin
                op  = 16'($urandom_range(0, 400));
                len = $urandom_range(1, 3);
            end
        endcase
        q.insert(q.size(), {16'(len), op});
        for (int i = 1; i < len; i++) begin
            w = $urandom;
            if (op == OP_DECORATE_ID && i == 2)
                case ($urandom_range(0, 3))
                    0: w = DEC_COUNTER_BUFFER;
                    1: w = DEC_USER_TYPE;
                    2: w = DEC_SEMANTIC;
                    default: ;
                endcase
            q.insert(q.size(), w);
        end
    endfunction

    // Mostly well-formed modules; a few bad magic, short header, zero length
    // or ragged tail cases.
    function automatic void build_module(ref word_q_t q);
        int          r;
        int          n;
        logic [31:0] w;
        q.delete();
        r = $urandom_range(0, 99);
        if (r < 7) begin
            w = $urandom;
            if (w == MAGIC_WORD) w ^= 32'd1;
            q.insert(q.size(), w);
            repeat ($urandom_range(0, 3)) q.insert(q.size(), $urandom);
            return;
        end
        q.insert(q.size(), MAGIC_WORD);
        if (r < 12) begin
            repeat ($urandom_range(0, 3)) q.insert(q.size(), $urandom);
            return;
        end
        repeat (4) q.insert(q.size(), $urandom);
        n = $urandom_range(0, 5);
        repeat (n) add_instr(q);
        r = $urandom_range(0, 99);
        if (r < 8) begin
            q.insert(q.size(), {16'd0, 16'($urandom)});
            repeat ($urandom_range(0, 3)) q.insert(q.size(), $urandom);
        end else if (r < 16 && n > 0) begin
            repeat ($urandom_range(1, 2))
                if (q.size() > 6) void'(q.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        word_q_t mod_q;
        int      start;

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // bad magic ending the module at once, then bad magic with a tail
        send_module('{32'h0000_0000});
        send_module('{32'hFFFF_FFFF, MAGIC_WORD});
        // header cut after two words
        send_module('{MAGIC_WORD, 32'hFFFF_FFFF});
        // zero-length instruction, then a swallowed word
        send_module('{MAGIC_WORD, 32'h0, 32'h0, 32'h0, 32'h0,
                      32'h0000_FFFF, 32'h1234_5678});
        // decoration too short to carry its kind is kept; then an
        // instruction of maximum length runs past the end of the module
        send_module('{MAGIC_WORD, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h0000_0001, {16'd2, OP_DECORATE_ID}, 32'h5555_5555,
                      {16'hFFFF, OP_UNDEF}, 32'hFFFF_FFFF});
        wait_drained();

        // random part in three handshake profiles, drained between them
        start = n_sent;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 46 : 0;
            recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 15 : 0;
            while (n_sent < start + RANDOM_ITEMS * (ph + 1) / 3) begin
                build_module(mod_q);
                send_module(mod_q);
            end
            wait_drained();
        end

        // anything showing up now is a spurious result
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
